>>> hdl/dnt_pkg.sv
// Shared types and constants of the dense neuron with rational tanh.
package dnt_pkg;

    // Q8.8 data format of every field
    localparam int DATA_W    = 16;
    localparam int FRAC_BITS = 8;

    // Stream widths: activation, weight and bias in the slave tdata
    localparam int S_TDATA_W = 3 * DATA_W;
    localparam int M_TDATA_W = DATA_W;

    // Queue of saturated sums between the front and the back part
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int PEND_W      = QCNT_W + 1;

    // Rational tanh datapath: s(27+s^2)/(27+9s^2), s in Q8.8
    localparam int SQ_W    = 2 * DATA_W - 1;          // |s|^2 <= 2^30
    localparam int KSUM_W  = SQ_W;                    // 27*2^16 + s^2 < 2^31
    localparam int NUM_W   = DATA_W + KSUM_W;         // |s| * (k + s^2)
    localparam int DEN_W   = SQ_W + 3;                // k + 9 s^2 < 2^34
    localparam int QUO_W   = DATA_W;                  // quotient never exceeds |s|
    localparam int DIV_W   = DEN_W + QUO_W - 1;       // divisor shifted to the top
    localparam int STEP_W  = $clog2(QUO_W);
    localparam int K_INT   = 27 * (1 << (2 * FRAC_BITS));

    typedef logic signed [DATA_W-1:0] data_t;

    localparam data_t DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam data_t DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // One saturated sum handed from the front to the queue
    typedef struct packed {
        logic  valid;
        data_t data;
    } push_t;

    // Queue fill state seen by both neighbors
    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } q_status_t;

endpackage

>>> hdl/dnt_front.sv
// Front part: multiply-accumulate, bias add and saturation to Q8.8.
module dnt_front
    import dnt_pkg::*;
#(
    parameter int MAX_TERMS = 512
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  data_t     activation,
    input  data_t     weight,
    input  data_t     bias,
    input  logic      last,
    input  q_status_t q_status,
    output push_t     push
);

    localparam int ACC_W = 2 * DATA_W + $clog2(MAX_TERMS);
    localparam int SUM_W = ACC_W + 1;
    localparam int SH_W  = SUM_W - FRAC_BITS;

    logic                           accept;
    logic                           p1_valid_reg;
    logic                           p1_last_reg;
    logic signed [2*DATA_W-1:0]     p1_prod_reg;
    data_t                          p1_bias_reg;
    logic        [ACC_W-1:0]        acc_reg;
    logic        [ACC_W-1:0]        acc_next;
    logic                           t_valid_reg;
    logic signed [ACC_W-1:0]        t_total_reg;
    data_t                          t_bias_reg;
    logic        [PEND_W-1:0]       pending;
    logic signed [SUM_W-1:0]        sum;
    logic        [SH_W-1:0]         shifted;
    logic        [SH_W-DATA_W:0]    top;
    data_t                          sat;

    // Hold off new transfers once every queue slot is spoken for
    assign pending = PEND_W'(q_status.count) + PEND_W'(p1_valid_reg & p1_last_reg)
                   + PEND_W'(t_valid_reg);
    assign in_ready = pending < PEND_W'(QUEUE_DEPTH);
    assign accept   = in_valid & in_ready;

    // Accumulate modulo 2^ACC_W
    assign acc_next = acc_reg + ACC_W'(p1_prod_reg);

    // Register the product of each transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= accept;
        end
        if (accept) begin
            p1_prod_reg <= activation * weight;
            p1_bias_reg <= bias;
            p1_last_reg <= last;
        end
    end

    // Advance the accumulator; capture and clear it on the last term
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            t_valid_reg <= 1'b0;
        end else begin
            t_valid_reg <= p1_valid_reg & p1_last_reg;
            if (p1_valid_reg) begin
                acc_reg <= p1_last_reg ? '0 : acc_next;
            end
        end
        if (p1_valid_reg && p1_last_reg) begin
            t_total_reg <= $signed(acc_next);
            t_bias_reg  <= p1_bias_reg;
        end
    end

    // Add bias, drop fraction bits toward minus infinity, saturate
    assign sum     = SUM_W'(t_total_reg) + SUM_W'($signed({t_bias_reg, {FRAC_BITS{1'b0}}}));
    assign shifted = sum[SUM_W-1:FRAC_BITS];
    assign top     = shifted[SH_W-1:DATA_W-1];

    always_comb begin
        if ((&top) || !(|top)) begin
            sat = $signed(shifted[DATA_W-1:0]);
        end else if (shifted[SH_W-1]) begin
            sat = DATA_MIN;
        end else begin
            sat = DATA_MAX;
        end
    end

    assign push.valid = t_valid_reg;
    assign push.data  = sat;

endmodule

>>> hdl/dnt_queue.sv
// Short queue of saturated sums between the front and the back part.
module dnt_queue
    import dnt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  push_t     push,
    input  logic      pop,
    output data_t     rd_data,
    output q_status_t q_status
);

    data_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Pointers wrap on their own: the depth is a power of two
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push.valid, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    // Store the pushed sum
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entry_reg[wr_ptr_reg] <= push.data;
        end
    end

    assign rd_data        = entry_reg[rd_ptr_reg];
    assign q_status.empty = (count_reg == '0);
    assign q_status.count = count_reg;

endmodule

>>> hdl/dnt_back.sv
// Back part: rational tanh with a shift-subtract divider and output register.
module dnt_back
    import dnt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  q_status_t            q_status,
    input  data_t                q_data,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SQUARE = 6'b000010,
        ST_SUMS   = 6'b000100,
        ST_PRODS  = 6'b001000,
        ST_DIVIDE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t              state_reg;
    logic                neg_reg;
    logic [DATA_W-1:0]   mag_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [KSUM_W-1:0]   ksum_reg;
    logic [DEN_W-1:0]    nine_reg;
    logic [DIV_W-1:0]    rem_reg;
    logic [DIV_W-1:0]    dvs_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [DATA_W-1:0]   q_bits;
    logic [NUM_W-1:0]    num;
    logic [DEN_W-1:0]    den;
    logic                ge;
    logic                out_free;

    assign q_bits   = q_data;
    assign num      = NUM_W'(mag_reg) * NUM_W'(ksum_reg);
    assign den      = nine_reg + DEN_W'(K_INT);
    assign ge       = rem_reg >= dvs_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == ST_IDLE) && !q_status.empty;

    // Sequence one sum through square, sums, products and division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (!q_status.empty) begin
                        state_reg <= ST_SQUARE;
                    end
                end
                ST_SQUARE: state_reg <= ST_SUMS;
                ST_SUMS:   state_reg <= ST_PRODS;
                ST_PRODS:  state_reg <= ST_DIVIDE;
                ST_DIVIDE: begin
                    if (step_reg == '0) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Raise the result when the quotient is ready, drop it after its transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((state_reg == ST_DONE) && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                neg_reg <= q_bits[DATA_W-1];
                mag_reg <= q_bits[DATA_W-1] ? (~q_bits + 1'b1) : q_bits;
            end
            ST_SQUARE: begin
                sq_reg <= SQ_W'(mag_reg) * SQ_W'(mag_reg);
            end
            ST_SUMS: begin
                ksum_reg <= KSUM_W'(K_INT) + sq_reg;
                nine_reg <= (DEN_W'(sq_reg) << 3) + DEN_W'(sq_reg);
            end
            ST_PRODS: begin
                rem_reg  <= DIV_W'(num);
                dvs_reg  <= DIV_W'(den) << (QUO_W - 1);
                quo_reg  <= '0;
                step_reg <= STEP_W'(QUO_W - 1);
            end
            ST_DIVIDE: begin
                if (ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                quo_reg  <= {quo_reg[QUO_W-2:0], ge};
                dvs_reg  <= dvs_reg >> 1;
                step_reg <= step_reg - 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_data_reg <= neg_reg ? (~quo_reg + 1'b1) : quo_reg;
                end
            end
            default: begin
                quo_reg <= quo_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> hdl/dense_neuron_tanh_approx_unit.sv
// Top level of the dense neuron with rational tanh.
//
// Each slave transfer carries one term of the dot product: the product is
// registered, then added to the accumulator; while s_tready is high, a new term
// is taken even as the previous one is still being added. On the transfer with
// tlast the biased, saturated sum s enters a four-entry queue, and the back part
// computes s(27+s^2)/(27+9s^2) in Q8.8. The back part takes each sum through
// square, sums, products and a shift-subtract divider to its output register,
// and pops the next sum only after the result has gone to that register.
// s_tready drops while four sums are queued or still in the front pipeline.
module dense_neuron_tanh_approx_unit
    import dnt_pkg::*;
#(
    parameter int MAX_TERMS = 512
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // activation, weight, bias
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // tanh_value
);

    push_t     push;
    logic      pop;
    data_t     q_data;
    q_status_t q_status;

    dnt_front #(
        .MAX_TERMS (MAX_TERMS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .activation ($signed(s_tdata[DATA_W-1:0])),
        .weight     ($signed(s_tdata[2*DATA_W-1:DATA_W])),
        .bias       ($signed(s_tdata[3*DATA_W-1:2*DATA_W])),
        .last       (s_tlast),
        .q_status   (q_status),
        .push       (push)
    );

    dnt_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .pop      (pop),
        .rd_data  (q_data),
        .q_status (q_status)
    );

    dnt_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

>>> hdl/dnt_checker.sv
// Port-level checks of the dense neuron with rational tanh, bound to the top.
module dnt_checker
    import dnt_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int OUT_W = 4;

    logic [OUT_W-1:0] open_reg;
    logic             last_in;
    logic             res_out;

    assign last_in = s_tvalid && s_tready && s_tlast;
    assign res_out = m_tvalid && m_tready;

    // Count tlast transfers whose result has not left yet
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= '0;
        end else begin
            open_reg <= open_reg + OUT_W'(last_in) - OUT_W'(res_out);
        end
    end

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> open_reg != '0)
        else $error("result without a pending tlast transfer");

    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> open_reg >= OUT_W'(QUEUE_DEPTH))
        else $error("input stalled with queue room left");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        open_reg <= OUT_W'(QUEUE_DEPTH + 2))
        else $error("too many pending results");

endmodule

bind dense_neuron_tanh_approx_unit dnt_checker u_dnt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
